@@ rtl/fmcc_pkg.sv @@
// Shared constants, types and code-rotation functions for the fiducial marker code check.
`timescale 1ns / 1ps
package fmcc_pkg;
	localparam int GRID_CELLS    = 7;
	localparam int MAX_CELL_SIZE = 64;
	localparam int INNER_N       = GRID_CELLS - 2;
	localparam int CODE_BITS     = INNER_N * INNER_N;
	localparam int REF_W         = 25;
	localparam int CODE_EXT      = (CODE_BITS > REF_W) ? CODE_BITS : REF_W;
	localparam int POS_W         = 10;
	localparam int CS_W          = 7;
	localparam int THR_W         = 13;
	localparam int CNT_W         = 13;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int SPAN_W        = $clog2(GRID_CELLS * MAX_CELL_SIZE + 1);
	localparam int CMP_W         = (SPAN_W > POS_W + 1) ? SPAN_W : POS_W + 1;
	localparam int CFG_IDX_W     = 3;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CELL_SIZE,
		CFG_IMAGE_SIDE,
		CFG_BIT_THR,
		CFG_BORDER_THR,
		CFG_REF_CODE
	} cfg_idx_t;

	typedef struct packed {
		logic [CS_W-1:0]  cell_size;
		logic [POS_W-1:0] image_side;
		logic [THR_W-1:0] bit_thr;
		logic [THR_W-1:0] border_thr;
		logic [REF_W-1:0] ref_code;
	} fmcc_cfg_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 border_failed;
	} fmcc_rec_t;

	function automatic int bit_pos(input int r, input int c);
		return CODE_BITS - 1 - (r * INNER_N + c);
	endfunction

	// clockwise quarter turn: new[r][c] = old[N-1-c][r]
	function automatic logic [CODE_BITS-1:0] rot_cw(input logic [CODE_BITS-1:0] code);
		logic [CODE_BITS-1:0] res;
		res = '0;
		for (int r = 0; r < INNER_N; r++) begin
			for (int c = 0; c < INNER_N; c++) begin
				res[bit_pos(r, c)] = code[bit_pos(INNER_N - 1 - c, r)];
			end
		end
		return res;
	endfunction

	function automatic logic [REF_W-1:0] low_code(input logic [CODE_BITS-1:0] code);
		logic [CODE_EXT-1:0] ext;
		ext = CODE_EXT'(code);
		return ext[REF_W-1:0];
	endfunction
endpackage

@@ rtl/fmcc_front.sv @@
// Front end: pixel position tracking, per-cell counting and band judging.
`timescale 1ns / 1ps
module fmcc_front import fmcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fmcc_cfg_t  cfg,
	input  logic       take,
	input  logic       pixel_set,
	output logic       rec_push,
	output fmcc_rec_t  rec
);
	logic [POS_W-1:0]     col_q, row_q;
	logic [CNT_W-1:0]     counts_q [GRID_CELLS];
	logic [CODE_BITS-1:0] bits_q;
	logic                 bfail_q;

	logic [CMP_W-1:0]     cs_eff, side_eff, col_ext, row_ext;
	logic [CMP_W-1:0]     mult [GRID_CELLS+1];
	logic [CNT_W-1:0]     cnt_nx [GRID_CELLS];
	logic [GRID_CELLS-1:0] over_bit, over_border, band_end;
	logic                 row_in, last_col, last_row, band_hit, edge_row, fail;
	logic [CODE_BITS-1:0] bits_set, bits_nx;
	logic                 bfail_nx;

	always_comb begin
		if (cfg.cell_size == '0) begin
			cs_eff = CMP_W'(1);
		end else if (CMP_W'(cfg.cell_size) > CMP_W'(MAX_CELL_SIZE)) begin
			cs_eff = CMP_W'(MAX_CELL_SIZE);
		end else begin
			cs_eff = CMP_W'(cfg.cell_size);
		end
		side_eff = (cfg.image_side == '0) ? CMP_W'(1) : CMP_W'(cfg.image_side);
		col_ext  = CMP_W'(col_q);
		row_ext  = CMP_W'(row_q);
		for (int k = 0; k <= GRID_CELLS; k++) begin
			mult[k] = CMP_W'(k) * cs_eff;
		end
		row_in = row_ext < mult[GRID_CELLS];
		for (int c = 0; c < GRID_CELLS; c++) begin
			cnt_nx[c] = counts_q[c] + CNT_W'(take && pixel_set && row_in &&
				col_ext >= mult[c] && col_ext < mult[c+1] && counts_q[c] != CNT_MAX);
			over_bit[c]    = cnt_nx[c] > cfg.bit_thr;
			over_border[c] = cnt_nx[c] > cfg.border_thr;
			band_end[c]    = (row_ext + CMP_W'(1)) == mult[c+1];
		end
		last_col = !((col_ext + CMP_W'(1)) < side_eff);
		last_row = !((row_ext + CMP_W'(1)) < side_eff);
		band_hit = last_col && (|band_end);
		edge_row = band_end[0] | band_end[GRID_CELLS-1];
		fail = 1'b0;
		for (int c = 0; c < GRID_CELLS; c++) begin
			if (over_border[c] && (edge_row || c == 0 || c == GRID_CELLS - 1)) begin
				fail = 1'b1;
			end
		end
		bits_set = '0;
		for (int r = 1; r < GRID_CELLS - 1; r++) begin
			for (int c = 1; c < GRID_CELLS - 1; c++) begin
				bits_set[bit_pos(r - 1, c - 1)] = band_end[r] & over_bit[c];
			end
		end
		bits_nx  = band_hit ? (bits_q | bits_set) : bits_q;
		bfail_nx = bfail_q | (band_hit & fail);
	end

	assign rec_push          = take && last_col && last_row;
	assign rec.code          = bits_nx;
	assign rec.border_failed = bfail_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			bits_q  <= '0;
			bfail_q <= 1'b0;
			for (int c = 0; c < GRID_CELLS; c++) begin
				counts_q[c] <= '0;
			end
		end else if (take) begin
			if (!last_col) begin
				col_q <= col_q + POS_W'(1);
				for (int c = 0; c < GRID_CELLS; c++) begin
					counts_q[c] <= cnt_nx[c];
				end
			end else begin
				col_q <= '0;
				if (last_row) begin
					row_q   <= '0;
					bits_q  <= '0;
					bfail_q <= 1'b0;
					for (int c = 0; c < GRID_CELLS; c++) begin
						counts_q[c] <= '0;
					end
				end else begin
					row_q   <= row_q + POS_W'(1);
					bits_q  <= bits_nx;
					bfail_q <= bfail_nx;
					for (int c = 0; c < GRID_CELLS; c++) begin
						counts_q[c] <= band_hit ? '0 : cnt_nx[c];
					end
				end
			end
		end
	end
endmodule

@@ rtl/fmcc_queue.sv @@
// Short queue of finished image records between front and back.
`timescale 1ns / 1ps
module fmcc_queue import fmcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  fmcc_rec_t wr_rec,
	input  logic      rd_en,
	output fmcc_rec_t rd_rec,
	output logic      not_empty,
	output logic      full
);
	fmcc_rec_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr, do_rd;

	assign not_empty = count_q != '0;
	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end
endmodule

@@ rtl/fmcc_back.sv @@
// Back end: rotation match against the reference code and result register.
`timescale 1ns / 1ps
module fmcc_back import fmcc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  fmcc_rec_t        head,
	input  logic             head_valid,
	input  logic [REF_W-1:0] ref_code,
	input  logic             pop,
	output logic             deq,
	output logic             empty,
	output logic             marker_found,
	output logic             border_black,
	output logic [1:0]       rotation_count,
	output logic [REF_W-1:0] code_value
);
	logic [CODE_BITS-1:0] rots [4];
	logic [3:0]           match;
	logic [1:0]           turns;
	logic                 found;
	logic                 out_valid_q;
	logic                 found_q, black_q;
	logic [1:0]           turns_q;
	logic [REF_W-1:0]     code_q;

	always_comb begin
		rots[0] = head.code;
		for (int k = 1; k < 4; k++) begin
			rots[k] = rot_cw(rots[k-1]);
		end
		for (int k = 0; k < 4; k++) begin
			match[k] = low_code(rots[k]) == ref_code;
		end
		if (match[0]) begin
			turns = 2'd0;
		end else if (match[1]) begin
			turns = 2'd1;
		end else if (match[2]) begin
			turns = 2'd2;
		end else begin
			turns = 2'd3;
		end
		found = (|match) && !head.border_failed;
	end

	assign deq   = head_valid && (!out_valid_q || pop);
	assign empty = !out_valid_q;

	assign marker_found   = found_q;
	assign border_black   = black_q;
	assign rotation_count = turns_q;
	assign code_value     = code_q;

	always_ff @(posedge clk) begin
		if (deq) begin
			found_q <= found;
			black_q <= !head.border_failed;
			turns_q <= found ? turns : 2'd0;
			code_q  <= low_code(head.code);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (deq) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end
endmodule

@@ rtl/fiducial_marker_code_check.sv @@
// Top level of the 7x7 fiducial marker code check: config registers and part wiring.
//  channel  | handshake           | payload
//  pixels   | push / full         | pixel_set
//  results  | empty / pop         | marker_found, border_black, rotation_count, code_value
//  config   | cfg_valid/cfg_ready | cfg_index, cfg_data
// One pixel request per clock while full is low; the front counts it in the same cycle it is taken.
// A result reaches the ports through the record queue, then the result register.
// Throughput is set by the front counter path; the back matches one image per clock
// while the result register is empty or being popped.
// full rises only when the two-entry record queue is full behind an unread result.
// Reset is asynchronous and needs no clearing pass; cfg_ready is always high.
`timescale 1ns / 1ps
module fiducial_marker_code_check import fmcc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 pixel_set,
	output logic                 empty,
	input  logic                 pop,
	output logic                 marker_found,
	output logic                 border_black,
	output logic [1:0]           rotation_count,
	output logic [REF_W-1:0]     code_value,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REF_W-1:0]     cfg_data
);
	fmcc_cfg_t cfg_q;
	fmcc_rec_t rec, head;
	logic      take, rec_push, head_valid, deq;

	assign cfg_ready = 1'b1;
	assign take      = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_size  <= CS_W'(16);
			cfg_q.image_side <= POS_W'(112);
			cfg_q.bit_thr    <= THR_W'(128);
			cfg_q.border_thr <= THR_W'(128);
			cfg_q.ref_code   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CELL_SIZE:  cfg_q.cell_size  <= cfg_data[CS_W-1:0];
				CFG_IMAGE_SIDE: cfg_q.image_side <= cfg_data[POS_W-1:0];
				CFG_BIT_THR:    cfg_q.bit_thr    <= cfg_data[THR_W-1:0];
				CFG_BORDER_THR: cfg_q.border_thr <= cfg_data[THR_W-1:0];
				CFG_REF_CODE:   cfg_q.ref_code   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fmcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.take     (take),
		.pixel_set(pixel_set),
		.rec_push (rec_push),
		.rec      (rec)
	);

	fmcc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (rec_push),
		.wr_rec   (rec),
		.rd_en    (deq),
		.rd_rec   (head),
		.not_empty(head_valid),
		.full     (full)
	);

	fmcc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_valid    (head_valid),
		.ref_code      (cfg_q.ref_code),
		.pop           (pop),
		.deq           (deq),
		.empty         (empty),
		.marker_found  (marker_found),
		.border_black  (border_black),
		.rotation_count(rotation_count),
		.code_value    (code_value)
	);
endmodule

@@ rtl/fmcc_checker.sv @@
// Port-level checker for the fiducial marker code check, bound to the top level.
`timescale 1ns / 1ps
module fmcc_checker import fmcc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input logic             marker_found,
	input logic             border_black,
	input logic [1:0]       rotation_count,
	input logic [REF_W-1:0] code_value
);
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(code_value) && $stable(marker_found)))
		else $error("waiting result changed or vanished");

	a_found_needs_border: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && marker_found) |-> border_black)
		else $error("marker found with failed border");

	a_turns_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !marker_found) |-> (rotation_count == 2'd0))
		else $error("rotation count set without a match");

	a_full_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input stalled with no result waiting");
endmodule

bind fiducial_marker_code_check fmcc_checker u_fmcc_checker (.*);
